/* hw/rtl/gss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gss_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 52;
    localparam int PROD_W = 64;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int DIM_W  = 6;
    localparam int IDX_W  = 3;

    localparam logic [2:0] ACT_LOAD_RHS = 3'd0;
    localparam logic [2:0] ACT_LOAD_SOL = 3'd1;
    localparam logic [2:0] ACT_SWEEP    = 3'd2;
    localparam logic [2:0] ACT_RESIDUAL = 3'd3;
    localparam logic [2:0] ACT_READ     = 3'd4;

    localparam logic [IDX_W-1:0] REG_ROWS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_COLS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_WEST  = 3'd2;
    localparam logic [IDX_W-1:0] REG_NORTH = 3'd3;
    localparam logic [IDX_W-1:0] REG_EAST  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SOUTH = 3'd5;
    localparam logic [IDX_W-1:0] REG_DIAG  = 3'd6;
    localparam logic [IDX_W-1:0] REG_INV   = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
        lo = -hi - ACC_W'(1);
        if (x > hi) begin
            sat_data = hi[DATA_W-1:0];
        end else if (x < lo) begin
            sat_data = lo[DATA_W-1:0];
        end else begin
            sat_data = x[DATA_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/gss_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module gss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/gss_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module gss_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [gss_pkg::SUM_W-1:0]   i_radicand,
    output gss_pkg::t_sqrt_stat              o_stat,
    output logic      [gss_pkg::ROOT_W-1:0]  o_root
);
    import gss_pkg::*;

    logic [SUM_W-1:0] r_x;
    logic [SUM_W-1:0] r_res;
    logic [SUM_W-1:0] r_bit;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SUM_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_radicand;
                r_res  <= '0;
                r_bit  <= SUM_W'(1) << (SUM_W - 2);
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_res[ROOT_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/gauss_seidel_stencil_sweep.sv */
`timescale 1ns / 1ps
`default_nettype none
// Five-point Gauss-Seidel engine on two grids in Q16.16.
// Input channel s_*: tuser carries the action, tdata carries row, col and
// value. Loads write one point of the rhs or solution grid; a sweep runs one
// in-place row-major pass over the interior; a residual returns the L2 norm;
// a read returns one solution point. Output channel m_* returns exactly one
// transaction per input transaction.
// For sweeps and residuals the work per interior point is paced by the single
// read port of the solution memory, one neighbor fetched per cycle, and the
// one shared multiplier; a residual then waits on the bit-serial square root.
// Only one transaction is processed at a time; a new one is accepted while
// the previous result still sits in the output register.
// Reset restores the configuration defaults and empties the pipeline; grid
// memories are not cleared. When the receiver stalls, the result holds in
// the output register and the engine waits before handing over the next one.
module gauss_seidel_stencil_sweep #(
    parameter int MAX_INTERIOR_ROWS = 62,
    parameter int MAX_INTERIOR_COLS = 62
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // row[5:0], col[11:6], value[43:12], zero
    input  wire logic [2:0]   s_tuser,   // action[2:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [63:0]  m_tdata,   // read_value[31:0], residual_norm[63:32]
    output logic      [0:0]   m_tuser,   // norm_saturated[0]
    input  wire logic         i_cfg_we,
    input  wire logic [gss_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gss_pkg::DATA_W-1:0] i_cfg_data
);
    import gss_pkg::*;

    localparam int GRID_ROWS  = MAX_INTERIOR_ROWS + 2;
    localparam int GRID_COLS  = MAX_INTERIOR_COLS + 2;
    localparam int GRID_WORDS = GRID_ROWS * GRID_COLS;
    localparam int AW         = $clog2(GRID_WORDS);
    localparam int RW         = $clog2(GRID_ROWS);
    localparam int CW         = $clog2(GRID_COLS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_PT   = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [3:0] SWEEP_LAST = 4'd7;
    localparam logic [3:0] RES_LAST   = 4'd9;

    logic [2:0]               r_state;
    logic [DIM_W-1:0]         r_rows;
    logic [DIM_W-1:0]         r_cols;
    logic signed [DATA_W-1:0] r_coef [5];
    logic signed [DATA_W-1:0] r_inv;

    logic [RW-1:0]            r_row;
    logic [CW-1:0]            r_col;
    logic [3:0]               r_step;
    logic                     r_res_mode;
    logic signed [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0]        r_prod;
    logic [DATA_W-1:0]        r_mag;
    logic                     r_big;
    logic [SUM_W-1:0]         r_sum;
    logic                     r_sat;

    logic [DATA_W-1:0]        r_pend_read;
    logic [ROOT_W-1:0]        r_pend_norm;
    logic                     r_pend_sat;
    logic                     r_m_valid;
    logic [63:0]              r_m_data;
    logic                     r_m_sat;

    logic [2:0]               in_act;
    logic [5:0]               in_row;
    logic [5:0]               in_col;
    logic [DATA_W-1:0]        in_val;
    logic                     in_fire;
    logic                     in_inside;
    logic [AW-1:0]            in_addr;

    logic [RW-1:0]            nr;
    logic [CW-1:0]            nc;
    int                       center;
    int                       offs;
    logic [AW-1:0]            pt_addr;
    logic [AW-1:0]            ctr_addr;
    logic [3:0]               nterms;
    logic [3:0]               last_step;

    logic                     rhs_we;
    logic                     sol_we;
    logic [AW-1:0]            sol_waddr;
    logic [DATA_W-1:0]        sol_wdata;
    logic                     sol_re;
    logic [AW-1:0]            sol_raddr;
    logic [DATA_W-1:0]        sol_rdata;
    logic                     rhs_re;
    logic [DATA_W-1:0]        rhs_rdata;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_p;
    logic                     mul_en;

    logic signed [ACC_W-1:0]  acc_abs;
    logic [SUM_W:0]           sum_add;
    logic                     sq_start;
    t_sqrt_stat               sq_stat;
    logic [ROOT_W-1:0]        sq_root;
    logic                     pt_last;

    assign in_act    = s_tuser;
    assign in_row    = s_tdata[5:0];
    assign in_col    = s_tdata[11:6];
    assign in_val    = s_tdata[43:12];
    assign s_tready  = (r_state == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_inside = (int'(in_row) < GRID_ROWS) && (int'(in_col) < GRID_COLS);
    assign in_addr   = AW'(int'(in_row) * GRID_COLS + int'(in_col));

    assign nr = (int'(r_rows) > MAX_INTERIOR_ROWS) ? RW'(MAX_INTERIOR_ROWS) : RW'(r_rows);
    assign nc = (int'(r_cols) > MAX_INTERIOR_COLS) ? CW'(MAX_INTERIOR_COLS) : CW'(r_cols);

    assign nterms    = r_res_mode ? 4'd5 : 4'd4;
    assign last_step = r_res_mode ? RES_LAST : SWEEP_LAST;
    assign pt_last   = (r_state == ST_PT) && (r_step == last_step);

    always_comb begin
        center = int'(r_row) * GRID_COLS + int'(r_col);
        case (r_step)
            4'd0:    offs = -1;
            4'd1:    offs = -GRID_COLS;
            4'd2:    offs = 1;
            4'd3:    offs = GRID_COLS;
            default: offs = 0;
        endcase
        pt_addr  = AW'(center + offs);
        ctr_addr = AW'(center);
    end

    assign rhs_we    = in_fire && (in_act == ACT_LOAD_RHS) && in_inside;
    assign rhs_re    = (r_state == ST_PT) && (r_step == 4'd0);
    assign sol_re    = (in_fire && (in_act == ACT_READ))
                    || ((r_state == ST_PT) && (r_step < nterms));
    assign sol_raddr = (r_state == ST_PT) ? pt_addr : in_addr;
    assign sol_we    = (in_fire && (in_act == ACT_LOAD_SOL) && in_inside)
                    || ((r_state == ST_PT) && !r_res_mode && (r_step == SWEEP_LAST));
    assign sol_waddr = (r_state == ST_PT) ? ctr_addr : in_addr;
    assign sol_wdata = (r_state == ST_PT)
                     ? sat_data(ACC_W'($signed(r_prod) >>> 16)) : in_val;

    gss_ram #(.WIDTH(DATA_W), .DEPTH(GRID_WORDS)) u_rhs (
        .i_clk   (i_clk),
        .i_we    (rhs_we),
        .i_waddr (in_addr),
        .i_wdata (in_val),
        .i_re    (rhs_re),
        .i_raddr (ctr_addr),
        .o_rdata (rhs_rdata)
    );

    gss_ram #(.WIDTH(DATA_W), .DEPTH(GRID_WORDS)) u_sol (
        .i_clk   (i_clk),
        .i_we    (sol_we),
        .i_waddr (sol_waddr),
        .i_wdata (sol_wdata),
        .i_re    (sol_re),
        .i_raddr (sol_raddr),
        .o_rdata (sol_rdata)
    );

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        if (r_state == ST_PT) begin
            if ((r_step >= 4'd1) && (r_step <= nterms)) begin
                mul_a  = 33'(r_coef[3'(r_step - 4'd1)]);
                mul_b  = 33'($signed(sol_rdata));
                mul_en = 1'b1;
            end else if (!r_res_mode && (r_step == 4'd6)) begin
                mul_a  = 33'(sat_data(r_acc));
                mul_b  = 33'(r_inv);
                mul_en = 1'b1;
            end else if (r_res_mode && (r_step == 4'd8)) begin
                mul_a  = signed'({1'b0, r_mag});
                mul_b  = signed'({1'b0, r_mag});
                mul_en = 1'b1;
            end
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign sum_add = {1'b0, r_sum} + {1'b0, r_prod};
    assign sq_start = pt_last && r_res_mode && (r_col == nc) && (r_row == nr);

    gss_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_big ? {SUM_W{1'b1}} : (sum_add[SUM_W] ? {SUM_W{1'b1}}
                                                              : sum_add[SUM_W-1:0])),
        .o_stat     (sq_stat),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_W'(62);
            r_cols  <= DIM_W'(62);
            r_coef  <= '{'0, '0, '0, '0, DATA_W'(65536)};
            r_inv   <= DATA_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS:  r_rows    <= i_cfg_data[DIM_W-1:0];
                REG_COLS:  r_cols    <= i_cfg_data[DIM_W-1:0];
                REG_WEST:  r_coef[0] <= i_cfg_data;
                REG_NORTH: r_coef[1] <= i_cfg_data;
                REG_EAST:  r_coef[2] <= i_cfg_data;
                REG_SOUTH: r_coef[3] <= i_cfg_data;
                REG_DIAG:  r_coef[4] <= i_cfg_data;
                REG_INV:   r_inv     <= i_cfg_data;
                default:   r_inv     <= r_inv;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p[PROD_W-1:0];
        end
        if (r_state == ST_PT) begin
            if (r_step == 4'd1) begin
                r_acc <= ACC_W'($signed(rhs_rdata));
            end else if ((r_step >= 4'd2) && (r_step <= nterms + 4'd1)) begin
                r_acc <= r_acc - ACC_W'($signed(r_prod) >>> 16);
            end
            if (r_res_mode && (r_step == 4'd7)) begin
                r_mag <= acc_abs[DATA_W-1:0];
                r_big <= (acc_abs[ACC_W-1:DATA_W] != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_step    <= '0;
        end else begin
            if (r_m_valid && m_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_pend_read <= '0;
                        r_pend_norm <= '0;
                        r_pend_sat  <= 1'b0;
                        r_row       <= RW'(1);
                        r_col       <= CW'(1);
                        r_step      <= '0;
                        r_sum       <= '0;
                        r_sat       <= 1'b0;
                        r_res_mode  <= (in_act == ACT_RESIDUAL);
                        if ((in_act == ACT_READ) && in_inside) begin
                            r_state <= ST_RD;
                        end else if (((in_act == ACT_SWEEP) || (in_act == ACT_RESIDUAL))
                                     && (nr != '0) && (nc != '0)) begin
                            r_state <= ST_PT;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_RD: begin
                    r_pend_read <= sol_rdata;
                    r_state     <= ST_OUT;
                end
                ST_PT: begin
                    if (r_res_mode && (r_step == RES_LAST)) begin
                        if (r_big || sum_add[SUM_W]) begin
                            r_sum <= {SUM_W{1'b1}};
                            r_sat <= 1'b1;
                        end else begin
                            r_sum <= sum_add[SUM_W-1:0];
                        end
                    end
                    if (pt_last) begin
                        r_step <= '0;
                        if (r_col == nc) begin
                            r_col <= CW'(1);
                            if (r_row == nr) begin
                                if (r_res_mode) begin
                                    r_pend_sat <= r_sat || r_big || sum_add[SUM_W];
                                    r_state    <= ST_SQ;
                                end else begin
                                    r_state <= ST_OUT;
                                end
                            end else begin
                                r_row <= r_row + RW'(1);
                            end
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_SQ: begin
                    if (sq_stat.done) begin
                        r_pend_norm <= sq_root;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_pend_norm, r_pend_read};
                        r_m_sat   <= r_pend_sat;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_sat;

    a_sq_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> (sq_stat.busy || sq_stat.done))
        else $error("square root idle while engine waits on it");

    a_sol_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sol_we |-> ((r_state == ST_IDLE) || ((r_state == ST_PT) && !r_res_mode)))
        else $error("solution write outside load or sweep");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && r_m_valid && !m_tready) |=> (r_state == ST_OUT))
        else $error("pending result overwrote stalled output");

    a_sq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |=> (r_state == ST_SQ))
        else $error("square root started outside residual end");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import gss_pkg::*;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
    localparam longint     Q_MAX = 64'sd2147483647;
    localparam longint     Q_MIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] read_value;
        logic [31:0] norm;
        logic        saturated;
    } t_grid_result;

    class stencil_scoreboard;
        longint       rhs [64][64];
        longint       sol [64][64];
        int           rows_reg;
        int           cols_reg;
        int           coef [8];
        t_grid_result pending_q[$];
        int           errors;
        int           checked;

        function new();
            rows_reg = 62;
            cols_reg = 62;
            foreach (coef[i]) coef[i] = 0;
            coef[REG_DIAG] = 65536;
            coef[REG_INV]  = 65536;
            errors  = 0;
            checked = 0;
            foreach (rhs[r, c]) begin
                rhs[r][c] = 0;
                sol[r][c] = 0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            if (idx == REG_ROWS) rows_reg = data[5:0];
            else if (idx == REG_COLS) cols_reg = data[5:0];
            else coef[idx] = data;
        endfunction

        function longint clamp(longint x);
            if (x > Q_MAX) return Q_MAX;
            if (x < Q_MIN) return Q_MIN;
            return x;
        endfunction

        function longint term(int k, longint u);
            return (longint'(coef[k]) * u) >>> 16;
        endfunction

        function longint stencil_rest(int r, int c);
            return rhs[r][c] - term(REG_WEST, sol[r][c-1]) - term(REG_NORTH, sol[r-1][c])
                   - term(REG_EAST, sol[r][c+1]) - term(REG_SOUTH, sol[r+1][c]);
        endfunction

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function int nrows();
            return rows_reg > 62 ? 62 : rows_reg;
        endfunction

        function int ncols();
            return cols_reg > 62 ? 62 : cols_reg;
        endfunction

        function void note_input(logic [2:0] act, int r, int c, logic [31:0] v);
            t_grid_result    e;
            longint          acc;
            longint unsigned mag;
            longint unsigned sq;
            longint unsigned sum;
            e.read_value = '0;
            e.norm       = '0;
            e.saturated  = 1'b0;
            case (act)
                ACT_LOAD_RHS: rhs[r][c] = longint'($signed(v));
                ACT_LOAD_SOL: sol[r][c] = longint'($signed(v));
                ACT_SWEEP: begin
                    for (int i = 1; i <= nrows(); i++)
                        for (int j = 1; j <= ncols(); j++) begin
                            acc = clamp(stencil_rest(i, j));
                            sol[i][j] = clamp((acc * longint'(coef[REG_INV])) >>> 16);
                        end
                end
                ACT_RESIDUAL: begin
                    sum = 0;
                    for (int i = 1; i <= nrows(); i++)
                        for (int j = 1; j <= ncols(); j++) begin
                            acc = stencil_rest(i, j) - term(REG_DIAG, sol[i][j]);
                            mag = acc < 0 ? -acc : acc;
                            if (mag > 64'hFFFF_FFFF) begin
                                sum = '1;
                                e.saturated = 1'b1;
                            end else begin
                                sq = mag * mag;
                                if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) begin
                                    sum = '1;
                                    e.saturated = 1'b1;
                                end else begin
                                    sum = sum + sq;
                                end
                            end
                        end
                    e.norm = 32'(isqrt(sum));
                end
                ACT_READ: e.read_value = 32'(sol[r][c]);
                default: ;
            endcase
            pending_q.push_back(e);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [31:0] rv, logic [31:0] norm, logic sat);
            t_grid_result e;
            checked++;
            if (pending_q.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                e = pending_q.pop_front();
                if (rv !== e.read_value)
                    report_mismatch($sformatf("read_value %h, want %h", rv, e.read_value));
                if (norm !== e.norm)
                    report_mismatch($sformatf("residual_norm %h, want %h", norm, e.norm));
                if (sat !== e.saturated)
                    report_mismatch($sformatf("norm_saturated %b, want %b", sat, e.saturated));
            end
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    stencil_scoreboard sb = new();
    bit quiet = 0;
    int stall_left = 0;
    int sweeps = 0;
    int residuals = 0;

    gauss_seidel_stencil_sweep dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) m_tready <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 1 << 19) - (1 << 18);
        endcase
    endfunction

    function automatic logic [31:0] rand_small();
        return $urandom_range(0, 1 << 19) - (1 << 18);
    endfunction

    task automatic send(logic [2:0] act, int r, int c, logic [31:0] v);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, v, c[5:0], r[5:0]};
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(act, r, c, v);
        if (act == ACT_SWEEP) sweeps++;
        if (act == ACT_RESIDUAL) residuals++;
    endtask

    task automatic load_region(int nr, int nc, bit wide);
        for (int r = 0; r <= nr + 1; r++)
            for (int c = 0; c <= nc + 1; c++) begin
                send(ACT_LOAD_RHS, r, c, wide ? rand_q() : rand_small());
                send(ACT_LOAD_SOL, r, c, wide ? rand_q() : rand_small());
            end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_config(int rows, int cols, logic [31:0] w, logic [31:0] n,
                                logic [31:0] e, logic [31:0] s, logic [31:0] d,
                                logic [31:0] inv);
        write_reg(REG_ROWS, {$urandom} & 32'hFFFF_FFC0 | rows);
        write_reg(REG_COLS, {$urandom} & 32'hFFFF_FFC0 | cols);
        write_reg(REG_WEST, w);
        write_reg(REG_NORTH, n);
        write_reg(REG_EAST, e);
        write_reg(REG_SOUTH, s);
        write_reg(REG_DIAG, d);
        write_reg(REG_INV, inv);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 2) == 0) return $urandom;
        return $urandom_range(0, 131072) - 65536;
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_config(0, 5, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
        send(ACT_SWEEP, 0, 0, 32'h0);
        send(ACT_RESIDUAL, 0, 0, 32'h0);
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            send(a[2:0], 63, 63, 32'hFFFF_FFFF);
        drain();

        write_config(2, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_C000, 32'h0004_0000,
                     32'h7FFF_FFFF, 32'h8000_0000);
        load_region(2, 2, 1'b1);
        send(ACT_READ, 0, 0, 32'h0);
        send(ACT_READ, 3, 3, 32'hFFFF_FFFF);
        send(ACT_RESIDUAL, 0, 0, 32'h0);
        send(ACT_SWEEP, 0, 0, 32'h0);
        send(ACT_RESIDUAL, 0, 0, 32'h0);
        send(ACT_READ, 1, 2, 32'h0);
        send(ACT_LOAD_RHS, 63, 0, 32'h7FFF_FFFF);
        send(ACT_LOAD_SOL, 0, 63, 32'h8000_0000);
        send(ACT_READ, 0, 63, 32'h0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            int nr;
            int nc;
            int k;
            nr = $urandom_range(0, 3);
            nc = $urandom_range(0, 3);
            write_config(nr, nc, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                         rand_coef(), rand_coef());
            if (ph == 2) quiet = 1;
            load_region(nr, nc, 1'b0);
            for (int i = 0; i < 9; i++) begin
                k = $urandom_range(0, 99);
                if (k < 20)
                    send(ACT_LOAD_RHS, $urandom_range(0, 63), $urandom_range(0, 63), rand_q());
                else if (k < 40)
                    send(ACT_LOAD_SOL, $urandom_range(0, 63), $urandom_range(0, 63), rand_q());
                else if (k < 55)
                    send(ACT_SWEEP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                else if (k < 70)
                    send(ACT_RESIDUAL, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                else if (k < 94)
                    send(ACT_READ, $urandom_range(0, nr + 1), $urandom_range(0, nc + 1),
                         $urandom);
                else
                    send(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                         $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            end
            drain();
        end

        $display("Covered small-grid loads, %0d sweeps and %0d residuals over several",
                 sweeps, residuals);
        $display("stencil settings; %0d results checked, %0d mismatches", sb.checked,
                 sb.errors);
        if (sb.errors == 0)
            $display("gauss_seidel_stencil_sweep test passed");
        else
            $display("gauss_seidel_stencil_sweep test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d transactions outstanding", sb.pending_q.size());
        $display("gauss_seidel_stencil_sweep test failed");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
hw/rtl/gss_pkg.sv
hw/rtl/gss_ram.sv
hw/rtl/gss_sqrt.sv
hw/rtl/gauss_seidel_stencil_sweep.sv
tb/tb_top.sv
